// ===== design/pif_pkg.sv =====
// Shared types and constants for the printf integer formatter.
`default_nettype none

package pif_pkg;

   localparam int MAX_WIDTH_DEFAULT   = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Octal of a 64-bit value needs the most digits.
   localparam int NUM_DIGITS = 22;
   localparam int DIGIT_BITS = NUM_DIGITS * 4;
   localparam int DIGIT_IDX_BITS = $clog2(NUM_DIGITS);
   localparam int VALUE_BITS = 64;

   localparam logic [2:0] FUNC_SDEC    = 3'd0;
   localparam logic [2:0] FUNC_UDEC    = 3'd1;
   localparam logic [2:0] FUNC_OCT     = 3'd2;
   localparam logic [2:0] FUNC_HEX     = 3'd3;
   localparam logic [2:0] FUNC_CHAR    = 3'd4;
   localparam logic [2:0] FUNC_PERCENT = 3'd5;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_X       = 8'h78;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_DEC,
      KIND_OCT,
      KIND_HEX
   } kind_type;

   // Field width after prefix reduction, may go down to -2.
   typedef logic signed [6:0] width_type;

   typedef struct packed {
      kind_type              kind;
      logic [VALUE_BITS-1:0] mag;
      logic                  neg;
      logic [1:0]            prefix_len;
      width_type             width;
      logic [7:0]            pad_ch;
      logic [7:0]            single_ch;
   } job_type;

endpackage

`default_nettype wire

// ===== design/pif_front.sv =====
// Front end: accepts a conversion request and turns it into a job for the back end.
`default_nettype none

module pif_front #(
   parameter int MAX_WIDTH = pif_pkg::MAX_WIDTH_DEFAULT
) (
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [2:0]       req_func,
   input  wire logic [63:0]      req_value,
   input  wire logic [1:0]       req_size_class,
   input  wire logic [5:0]       req_min_width,
   input  wire logic             req_zero_pad,
   input  wire logic             req_alternate,
   output logic                  push_valid,
   output pif_pkg::job_type      push_job,
   input  wire logic             push_ready
);

   logic [63:0] zext;
   logic [63:0] sext;
   logic [5:0]  width_sat;
   logic        keep;

   always_comb begin
      if (req_size_class == 2'd0) begin
         zext = {32'd0, req_value[31:0]};
         sext = {{32{req_value[31]}}, req_value[31:0]};
      end else begin
         zext = req_value;
         sext = req_value;
      end

      width_sat = (req_min_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : req_min_width;

      keep                = 1'b1;
      push_job.kind       = pif_pkg::KIND_SINGLE;
      push_job.mag        = zext;
      push_job.neg        = 1'b0;
      push_job.prefix_len = 2'd0;
      push_job.width      = pif_pkg::width_type'({1'b0, width_sat});
      push_job.pad_ch     = req_zero_pad ? pif_pkg::CHAR_ZERO : pif_pkg::CHAR_SPACE;
      push_job.single_ch  = req_value[7:0];

      unique case (req_func)
         pif_pkg::FUNC_SDEC: begin
            push_job.kind = pif_pkg::KIND_DEC;
            push_job.neg  = sext[63];
            push_job.mag  = sext[63] ? (64'd0 - sext) : sext;
         end
         pif_pkg::FUNC_UDEC: begin
            push_job.kind = pif_pkg::KIND_DEC;
         end
         pif_pkg::FUNC_OCT: begin
            push_job.kind = pif_pkg::KIND_OCT;
            push_job.mag  = sext;
            if (req_alternate) begin
               push_job.prefix_len = 2'd1;
               push_job.width = pif_pkg::width_type'({1'b0, width_sat})
                                - pif_pkg::width_type'(1);
            end
         end
         pif_pkg::FUNC_HEX: begin
            push_job.kind = pif_pkg::KIND_HEX;
            if (req_alternate) begin
               push_job.prefix_len = 2'd2;
               push_job.width = pif_pkg::width_type'({1'b0, width_sat})
                                - pif_pkg::width_type'(2);
            end
         end
         pif_pkg::FUNC_CHAR: begin
            push_job.kind = pif_pkg::KIND_SINGLE;
         end
         pif_pkg::FUNC_PERCENT: begin
            push_job.kind      = pif_pkg::KIND_SINGLE;
            push_job.single_ch = pif_pkg::CHAR_PERCENT;
         end
         default: begin
            // Unused kinds: take the transaction and drop it.
            keep = 1'b0;
         end
      endcase

      push_valid = req_valid && keep;
      req_stall  = !push_ready;
   end

endmodule

`default_nettype wire

// ===== design/pif_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module pif_queue #(
   parameter int DEPTH = pif_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire pif_pkg::job_type  push_job,
   output logic                   push_ready,
   output logic                   pop_valid,
   output pif_pkg::job_type       pop_job,
   input  wire logic              pop
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   pif_pkg::job_type    entries_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push_fire;
   logic                pop_fire;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("queue count above depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push_fire && !pop_fire |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// ===== design/pif_back.sv =====
// Back end: digit generation, digit count, and character emission.
`default_nettype none

module pif_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   input  wire pif_pkg::job_type  pop_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_ch,
   output logic                   rsp_last
);

   localparam int DB = pif_pkg::DIGIT_BITS;
   localparam int IB = pif_pkg::DIGIT_IDX_BITS;
   localparam int VB = pif_pkg::VALUE_BITS;
   // Two binary bits go into the BCD digits on every step.
   localparam int CONV_STEPS = VB / 2;
   localparam int STEP_BITS  = $clog2(CONV_STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_COUNT,
      ST_PLAN,
      ST_PREFIX,
      ST_PAD,
      ST_SIGN,
      ST_DIGITS,
      ST_SINGLE
   } state_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      if (d < 4'd10) begin
         return pif_pkg::CHAR_ZERO + {4'd0, d};
      end else begin
         return pif_pkg::CHAR_LOWER_A + {4'd0, d} - 8'd10;
      end
   endfunction

   state_type           state_ff, state_in;
   pif_pkg::kind_type   kind_ff, kind_in;
   logic                neg_ff, neg_in;
   logic [1:0]          prefix_left_ff, prefix_left_in;
   pif_pkg::width_type  width_ff, width_in;
   logic [7:0]          pad_ch_ff, pad_ch_in;
   logic [7:0]          single_ch_ff, single_ch_in;
   logic [DB-1:0]       digits_ff, digits_in;
   logic [VB-1:0]       bin_ff, bin_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [IB-1:0]       ndig_ff, ndig_in;
   logic [IB-1:0]       idx_ff, idx_in;
   logic [5:0]          pad_left_ff, pad_left_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_ch_ff, rsp_ch_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic [DB-1:0]       dd_digits;
   logic [VB-1:0]       dd_bin;
   logic [DB-1:0]       oct_digits;
   logic [IB-1:0]       lead;
   pif_pkg::width_type  ndig_w;
   logic                pad_need;
   logic [3:0]          nib;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ch    = rsp_ch_ff;
   assign rsp_last  = rsp_last_ff;

   // Double dabble, two bits per step.
   always_comb begin
      dd_digits = digits_ff;
      dd_bin    = bin_ff;
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < pif_pkg::NUM_DIGITS; i++) begin
            if (dd_digits[4*i +: 4] >= 4'd5) begin
               dd_digits[4*i +: 4] = dd_digits[4*i +: 4] + 4'd3;
            end
         end
         dd_digits = {dd_digits[DB-2:0], dd_bin[VB-1]};
         dd_bin    = {dd_bin[VB-2:0], 1'b0};
      end
   end

   always_comb begin
      for (int i = 0; i < pif_pkg::NUM_DIGITS; i++) begin
         oct_digits[4*i +: 4] = {1'b0, 3'(({2'b00, pop_job.mag} >> (3*i)))};
      end
   end

   // Highest nonzero digit; zero still counts as one digit.
   always_comb begin
      lead = '0;
      for (int i = 1; i < pif_pkg::NUM_DIGITS; i++) begin
         if (digits_ff[4*i +: 4] != 4'd0) begin
            lead = IB'(i);
         end
      end
   end

   assign ndig_w   = pif_pkg::width_type'({2'b00, ndig_ff});
   assign pad_need = (width_ff > ndig_w);
   assign nib      = digits_ff[{idx_ff, 2'b00} +: 4];
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      neg_in         = neg_ff;
      prefix_left_in = prefix_left_ff;
      width_in       = width_ff;
      pad_ch_in      = pad_ch_ff;
      single_ch_in   = single_ch_ff;
      digits_in      = digits_ff;
      bin_in         = bin_ff;
      step_in        = step_ff;
      ndig_in        = ndig_ff;
      idx_in         = idx_ff;
      pad_left_in    = pad_left_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_ch_in      = rsp_ch_ff;
      rsp_last_in    = rsp_last_ff;
      pop            = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               pop            = 1'b1;
               kind_in        = pop_job.kind;
               neg_in         = pop_job.neg;
               prefix_left_in = pop_job.prefix_len;
               width_in       = pop_job.width;
               pad_ch_in      = pop_job.pad_ch;
               single_ch_in   = pop_job.single_ch;
               bin_in         = pop_job.mag;
               step_in        = '0;
               unique case (pop_job.kind)
                  pif_pkg::KIND_SINGLE: begin
                     state_in = ST_SINGLE;
                  end
                  pif_pkg::KIND_DEC: begin
                     digits_in = '0;
                     state_in  = ST_CONVERT;
                  end
                  pif_pkg::KIND_OCT: begin
                     digits_in = oct_digits;
                     state_in  = ST_COUNT;
                  end
                  pif_pkg::KIND_HEX: begin
                     digits_in = {(DB-VB)'(0), pop_job.mag};
                     state_in  = ST_COUNT;
                  end
               endcase
            end
         end
         ST_CONVERT: begin
            digits_in = dd_digits;
            bin_in    = dd_bin;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_BITS'(CONV_STEPS - 1)) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            ndig_in  = lead + 1'b1;
            idx_in   = lead;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            pad_left_in = pad_need ? 6'(width_ff - ndig_w) : 6'd0;
            if (prefix_left_ff != 2'd0) begin
               state_in = ST_PREFIX;
            end else if (pad_need) begin
               state_in = ST_PAD;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGITS;
            end
         end
         ST_PREFIX: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_last_in    = 1'b0;
               rsp_ch_in      = (prefix_left_ff == 2'd1 && kind_ff == pif_pkg::KIND_HEX)
                                ? pif_pkg::CHAR_X : pif_pkg::CHAR_ZERO;
               prefix_left_in = prefix_left_ff - 1'b1;
               if (prefix_left_ff == 2'd1) begin
                  if (pad_left_ff != 6'd0) begin
                     state_in = ST_PAD;
                  end else if (neg_ff) begin
                     state_in = ST_SIGN;
                  end else begin
                     state_in = ST_DIGITS;
                  end
               end
            end
         end
         ST_PAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_ch_in    = pad_ch_ff;
               pad_left_in  = pad_left_ff - 1'b1;
               if (pad_left_ff == 6'd1) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_ch_in    = pif_pkg::CHAR_MINUS;
               state_in     = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ch_in    = digit_char(nib);
               rsp_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
         ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_ch_in    = single_ch_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff        <= kind_in;
      neg_ff         <= neg_in;
      prefix_left_ff <= prefix_left_in;
      width_ff       <= width_in;
      pad_ch_ff      <= pad_ch_in;
      single_ch_ff   <= single_ch_in;
      digits_ff      <= digits_in;
      bin_ff         <= bin_in;
      step_ff        <= step_in;
      ndig_ff        <= ndig_in;
      idx_ff         <= idx_in;
      pad_left_ff    <= pad_left_in;
      rsp_ch_ff      <= rsp_ch_in;
      rsp_last_ff    <= rsp_last_in;
   end

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != ST_IDLE)
      else $error("job taken but back end stayed idle");

   a_digit_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGITS |-> idx_ff < ndig_ff)
      else $error("digit index beyond digit count");

   a_pad_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAD |-> pad_left_ff != 6'd0)
      else $error("pad state entered with nothing to pad");

endmodule

`default_nettype wire

// ===== design/printf_integer_formatter_unit.sv =====
// Top level of the printf integer formatter: front end, job queue, back end.
//
// Usage: each req_ transaction carries one parsed conversion (kind, 64-bit
// value, size class, field width, zero-pad and alternate flags). The rsp_
// channel returns the resulting ASCII characters one per transaction, with
// rsp_last marking the final character of each conversion. Kinds six and
// seven are accepted and produce no characters.
// Operation: the front end classifies in the accept cycle and
// writes a job queue of QUEUE_DEPTH entries. The back end works on one job
// at a time: it takes the job in ST_IDLE, runs two-bit double dabble steps
// in ST_CONVERT for decimal kinds (none for octal, hex, char and percent),
// counts digits in ST_COUNT and plans padding in ST_PLAN (both skipped for
// char and percent), then emits one character per cycle while rsp_stall
// is low.
// Reset clears the queue and the back end; no clearing pass is needed.
// When the receiver raises rsp_stall, the character held in the output
// register waits, the back end stops, and once the queue fills req_stall
// rises.
`default_nettype none

module printf_integer_formatter_unit #(
   parameter int MAX_WIDTH   = pif_pkg::MAX_WIDTH_DEFAULT,
   parameter int QUEUE_DEPTH = pif_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [63:0] req_value,
   input  wire logic [1:0]  req_size_class,
   input  wire logic [5:0]  req_min_width,
   input  wire logic        req_zero_pad,
   input  wire logic        req_alternate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_ch,
   output logic             rsp_last
);

   logic             push_valid;
   logic             push_ready;
   pif_pkg::job_type push_job;
   logic             pop_valid;
   logic             pop;
   pif_pkg::job_type pop_job;

   pif_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_value       (req_value),
      .req_size_class  (req_size_class),
      .req_min_width   (req_min_width),
      .req_zero_pad    (req_zero_pad),
      .req_alternate   (req_alternate),
      .push_valid      (push_valid),
      .push_job        (push_job),
      .push_ready      (push_ready)
   );

   pif_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   pif_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_ch    (rsp_ch),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire
